// ----- rtl/lrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrsp_pkg
// shared types and status codes for the log record stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package lrsp_pkg;

	// one input transaction: a byte of the log image
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  byte_kind;
		logic [7:0]  payload_byte;
		logic        is_tombstone;
		logic [63:0] sequence_number;
		logic        batch_commit;
		logic        verdict_valid;
		logic [2:0]  parse_status;
		logic [31:0] good_offset;
	} out_item_t;

	// byte kinds
	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_KEY    = 2'd1;
	localparam logic [1:0] KIND_VALUE  = 2'd2;
	localparam logic [1:0] KIND_RECORD = 2'd3;

	// verdict codes
	localparam logic [2:0] ST_CLEAN      = 3'd0;
	localparam logic [2:0] ST_INCOMPLETE = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_OP     = 3'd3;
	localparam logic [2:0] ST_BAD_LEN    = 3'd4;
	localparam logic [2:0] ST_BAD_DELIM  = 3'd5;

	localparam logic [2:0] HEADER_LEN = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/lrsp_core.sv -----
// ----------------------------------------------------------------------------
// lrsp_core
// parse state and one-byte step logic; state advances on each enabled byte
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_core #(
	parameter int OFFSET_WIDTH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  lrsp_pkg::in_item_t   item,
	output lrsp_pkg::out_item_t  result
);
	import lrsp_pkg::*;

	typedef enum logic [3:0] {
		PH_COUNT,
		PH_OP,
		PH_OP_COMMA,
		PH_OP_COMMA_BAD,
		PH_SEQ,
		PH_KLEN,
		PH_KEY,
		PH_EQ,
		PH_VLEN,
		PH_VAL,
		PH_NL
	} phase_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;

	localparam logic [OFFSET_WIDTH-1:0] OFFS_RESET = OFFSET_WIDTH'(HEADER_LEN);

	logic [2:0]              hdr_q, hdr_d;
	phase_t                  phase_q, phase_d;
	logic [63:0]             acc_q, acc_d;
	logic                    seen_q, seen_d;
	logic                    ovf_q, ovf_d;
	logic [63:0]             field_q, field_d;
	logic [63:0]             recs_q, recs_d;
	logic                    tomb_q, tomb_d;
	logic [63:0]             seq_q, seq_d;
	logic [OFFSET_WIDTH-1:0] offs_q, offs_d;
	logic [OFFSET_WIDTH-1:0] bstart_q, bstart_d;
	logic [2:0]              status_q, status_d;

	logic [7:0]  b;
	logic [7:0]  want;
	logic        is_digit;
	logic [67:0] acc_x;
	logic        acc_ovf;
	logic        num_phase;
	logic        num_done;

	assign b = item.data_byte;

	// header byte expected at each position: "LWAL" then version 1
	always_comb begin
		case (hdr_q)
			3'd0:    want = 8'h4C;
			3'd1:    want = 8'h57;
			3'd2:    want = 8'h41;
			3'd3:    want = 8'h4C;
			default: want = 8'h01;
		endcase
	end

	// acc * 10 + digit, the top nibble flags a pass beyond 64 bits
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);
	assign acc_x    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(b[3:0]);
	assign acc_ovf  = |acc_x[67:64];

	assign num_phase = (phase_q == PH_COUNT) || (phase_q == PH_SEQ) ||
		(phase_q == PH_KLEN) || (phase_q == PH_VLEN);

	always_comb begin
		hdr_d    = hdr_q;
		phase_d  = phase_q;
		acc_d    = acc_q;
		seen_d   = seen_q;
		ovf_d    = ovf_q;
		field_d  = field_q;
		recs_d   = recs_q;
		tomb_d   = tomb_q;
		seq_d    = seq_q;
		offs_d   = offs_q + OFFSET_WIDTH'(1);
		bstart_d = bstart_q;
		status_d = status_q;
		num_done = 1'b0;
		result   = '0;

		if (status_q != ST_CLEAN) begin
			// sticky error: ignore until the last byte
		end else if (hdr_q < HEADER_LEN) begin
			if (b != want) begin
				status_d = ST_BAD_HEADER;
			end else begin
				hdr_d = hdr_q + 3'd1;
			end
		end else begin
			// shared decimal field handling
			if (num_phase) begin
				if (is_digit) begin
					if (acc_ovf) begin
						ovf_d = 1'b1;
					end else begin
						acc_d = acc_x[63:0];
					end
					seen_d = 1'b1;
				end else if (!seen_q) begin
					status_d = ST_BAD_LEN;
				end else if (ovf_q) begin
					status_d = ST_INCOMPLETE;
				end else if (b != CH_COMMA) begin
					status_d = ST_BAD_DELIM;
				end else begin
					num_done = 1'b1;
					acc_d    = '0;
					seen_d   = 1'b0;
					ovf_d    = 1'b0;
				end
			end

			case (phase_q)
				PH_COUNT: begin
					if (num_done) begin
						recs_d = acc_q;
						if (acc_q == '0) begin
							result.batch_commit = 1'b1;
							bstart_d = offs_d;
						end else begin
							phase_d = PH_OP;
						end
					end
				end
				PH_OP: begin
					if (b == CH_P) begin
						tomb_d  = 1'b0;
						phase_d = PH_OP_COMMA;
					end else if (b == CH_D) begin
						tomb_d  = 1'b1;
						phase_d = PH_OP_COMMA;
					end else begin
						phase_d = PH_OP_COMMA_BAD;
					end
				end
				PH_OP_COMMA: begin
					if (b == CH_COMMA) begin
						phase_d = PH_SEQ;
					end else begin
						status_d = ST_BAD_DELIM;
					end
				end
				PH_OP_COMMA_BAD: begin
					status_d = (b == CH_COMMA) ? ST_BAD_OP : ST_BAD_DELIM;
				end
				PH_SEQ: begin
					if (num_done) begin
						seq_d   = acc_q;
						phase_d = PH_KLEN;
					end
				end
				PH_KLEN: begin
					if (num_done) begin
						field_d = acc_q;
						phase_d = (acc_q != '0) ? PH_KEY : PH_EQ;
					end
				end
				PH_VLEN: begin
					if (num_done) begin
						field_d = acc_q;
						phase_d = (acc_q != '0) ? PH_VAL : PH_NL;
					end
				end
				PH_KEY: begin
					result.byte_kind    = KIND_KEY;
					result.payload_byte = b;
					field_d = field_q - 64'd1;
					if (field_q == 64'd1) begin
						phase_d = PH_EQ;
					end
				end
				PH_VAL: begin
					result.byte_kind    = KIND_VALUE;
					result.payload_byte = b;
					field_d = field_q - 64'd1;
					if (field_q == 64'd1) begin
						phase_d = PH_NL;
					end
				end
				PH_EQ: begin
					if (b == CH_EQ) begin
						phase_d = PH_VLEN;
					end else begin
						status_d = ST_BAD_DELIM;
					end
				end
				PH_NL: begin
					if (b == CH_NL) begin
						result.byte_kind       = KIND_RECORD;
						result.is_tombstone    = tomb_q;
						result.sequence_number = seq_q;
						recs_d = recs_q - 64'd1;
						if (recs_q == 64'd1) begin
							result.batch_commit = 1'b1;
							bstart_d = offs_d;
							phase_d  = PH_COUNT;
						end else begin
							phase_d = PH_OP;
						end
					end else begin
						status_d = ST_BAD_DELIM;
					end
				end
				default: begin
					phase_d = PH_COUNT;
					acc_d   = '0;
					seen_d  = 1'b0;
					ovf_d   = 1'b0;
				end
			endcase
		end

		// verdict on the final byte of the image
		if (item.last_byte) begin
			result.verdict_valid = 1'b1;
			result.good_offset   = 32'(bstart_d);
			if (status_d != ST_CLEAN) begin
				result.parse_status = status_d;
			end else if (hdr_d < HEADER_LEN) begin
				result.parse_status = ST_BAD_HEADER;
			end else if ((phase_d == PH_COUNT) && !seen_d) begin
				result.parse_status = ST_CLEAN;
			end else begin
				result.parse_status = ST_INCOMPLETE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			phase_q  <= PH_COUNT;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			ovf_q    <= 1'b0;
			field_q  <= '0;
			recs_q   <= '0;
			tomb_q   <= 1'b0;
			seq_q    <= '0;
			offs_q   <= '0;
			bstart_q <= OFFS_RESET;
			status_q <= ST_CLEAN;
		end else if (en) begin
			if (item.last_byte) begin
				// image done: start over for the next one
				hdr_q    <= '0;
				phase_q  <= PH_COUNT;
				acc_q    <= '0;
				seen_q   <= 1'b0;
				ovf_q    <= 1'b0;
				field_q  <= '0;
				recs_q   <= '0;
				tomb_q   <= 1'b0;
				seq_q    <= '0;
				offs_q   <= '0;
				bstart_q <= OFFS_RESET;
				status_q <= ST_CLEAN;
			end else begin
				hdr_q    <= hdr_d;
				phase_q  <= phase_d;
				acc_q    <= acc_d;
				seen_q   <= seen_d;
				ovf_q    <= ovf_d;
				field_q  <= field_d;
				recs_q   <= recs_d;
				tomb_q   <= tomb_d;
				seq_q    <= seq_d;
				offs_q   <= offs_d;
				bstart_q <= bstart_d;
				status_q <= status_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/log_record_stream_parser.sv -----
// ----------------------------------------------------------------------------
// log_record_stream_parser
// byte-serial parser for write-ahead-log images with tagged record output
// ----------------------------------------------------------------------------
// usage:
//   log channel (log_valid / log_stall / log_data) takes one byte of the image
//   per transaction; log_data.last_byte marks the final byte of an image.
//   res channel (res_valid / res_stall / res_data) gives exactly one result
//   transaction per input byte, in order: tagged key/value bytes, record
//   complete with sequence and tombstone flag, batch commit pulse, and on the
//   last byte the verdict with the offset after the last committed batch.
// path: a byte accepted into the input register is stepped and its result written to the result buffer.
// throughput: one byte per cycle while the result buffer has room; the step logic between
//   the input register and the result buffer is combinational.
// reset: arst_n clears the parse state to the start of a new image, empties
//   the input register and the result buffer. The last byte of an image also
//   returns the parse state to its start.
// stall: a two-entry result buffer lets the input register keep moving while
//   one result waits; log_stall rises only when the buffer is full and a byte
//   is held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_stream_parser #(
	parameter int OFFSET_WIDTH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  log_valid,
	output logic                 log_stall,
	input  lrsp_pkg::in_item_t   log_data,
	output logic                 res_valid,
	input  wire                  res_stall,
	output lrsp_pkg::out_item_t  res_data
);
	import lrsp_pkg::*;

	// input register
	logic      valid_s1;
	in_item_t  item_s1;

	// result buffer, two entries
	out_item_t buf_q [2];
	logic      wr_q;
	logic      rd_q;
	logic [1:0] count_q;

	out_item_t step_result;
	logic      take;
	logic      adv;
	logic      pop;
	logic      full;

	assign full      = (count_q == 2'd2);
	// step the byte in the input register whenever the buffer has room
	assign adv       = valid_s1 && !full;
	assign log_stall = valid_s1 && full;
	assign take      = log_valid && !log_stall;
	assign res_valid = (count_q != 2'd0);
	assign res_data  = buf_q[rd_q];
	assign pop       = res_valid && !res_stall;

	lrsp_core #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= log_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (adv) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({adv, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			buf_q[wr_q] <= step_result;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lrsp_checker.sv -----
// ----------------------------------------------------------------------------
// lrsp_checker
// port-level checks on the result channel of the parser
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 res_valid,
	input wire                 res_stall,
	input lrsp_pkg::out_item_t res_data
);
	import lrsp_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// verdict fields only with verdict_valid, with a legal code
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.verdict_valid ? (res_data.parse_status <= ST_BAD_DELIM) :
			(res_data.parse_status == ST_CLEAN && res_data.good_offset == 32'd0)))
		else $error("verdict fields outside a verdict");

	// record fields only on record complete
	a_record: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.byte_kind != KIND_RECORD) |->
			(res_data.sequence_number == 64'd0 && !res_data.is_tombstone))
		else $error("record fields outside record complete");

	// payload byte only on key or value bytes
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.byte_kind == KIND_FRAME || res_data.byte_kind == KIND_RECORD)
			|-> (res_data.payload_byte == 8'd0))
		else $error("payload byte outside key or value");

endmodule

bind log_record_stream_parser lrsp_checker u_lrsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

`default_nettype wire

// ----- bench/log_record_stream_parser_tb.sv -----
// ----------------------------------------------------------------------------
// log_record_stream_parser_tb
// self-checking bench for the write-ahead-log byte parser: builds log images
// (good, truncated, corrupted, noise), feeds them a byte per transaction and
// checks every result transaction against a cycle-free model of the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_record_stream_parser_tb;

	import lrsp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 1600;
	localparam int DRAIN_CYCLES = 8;

	// framing characters of the log format
	localparam logic [31:0] MAGIC_TEXT  = "LWAL";
	localparam logic [7:0]  WAL_VERSION = 8'd1;
	localparam logic [7:0]  CH_PUT      = "P";
	localparam logic [7:0]  CH_DEL      = "D";
	localparam logic [7:0]  CH_COMMA    = ",";
	localparam logic [7:0]  CH_EQUALS   = "=";
	localparam logic [7:0]  CH_NL       = 8'h0A;
	localparam logic [7:0]  CH_ZERO     = "0";
	localparam logic [7:0]  CH_NINE     = "9";

	// where the parser is within a batch
	typedef enum logic [3:0] {
		P_BATCH_COUNT,
		P_OPCODE,
		P_OPCODE_SEP,
		P_OPCODE_SEP_BAD,
		P_SEQUENCE,
		P_KEY_LEN,
		P_KEY_BYTES,
		P_EQUALS,
		P_VALUE_LEN,
		P_VALUE_BYTES,
		P_NEWLINE
	} wal_phase_e;

	logic clk;
	logic arst_n;
	logic log_valid;
	logic log_stall;
	in_item_t log_data;
	logic res_valid;
	logic res_stall;
	out_item_t res_data;

	log_record_stream_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.log_valid(log_valid),
		.log_stall(log_stall),
		.log_data(log_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// parser model state
	// ------------------------------------------------------------------------
	logic [2:0]  hdr_pos;
	wal_phase_e  phase;
	logic [63:0] acc;
	logic        acc_has_digit;
	logic        acc_overflow;
	logic [63:0] bytes_left;
	logic [63:0] records_left;
	logic        rec_is_delete;
	logic [63:0] rec_seq;
	logic [31:0] byte_pos;
	logic [31:0] commit_pos;
	logic [2:0]  err_code;

	// results still owed by the block, oldest first
	out_item_t expected_results[$];

	// bytes of the image under construction
	logic [7:0] image_bytes[$];

	// idle controls for the two sides, in percent
	int idle_pct;
	int stall_pct;

	// bookkeeping
	int fail_count;
	int cycle_count;
	int bytes_sent;
	int images_sent;
	int records_seen;
	int commits_seen;
	int verdict_tally[6];
	out_item_t want;

	// ------------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------------
	function automatic void clear_number();
		acc = '0;
		acc_has_digit = 1'b0;
		acc_overflow = 1'b0;
	endfunction

	function automatic void reset_parser_model();
		hdr_pos = '0;
		phase = P_BATCH_COUNT;
		clear_number();
		bytes_left = '0;
		records_left = '0;
		rec_is_delete = 1'b0;
		rec_seq = '0;
		byte_pos = '0;
		commit_pos = 32'd5;
		err_code = ST_CLEAN;
	endfunction

	// digit accumulation; true once the number is closed by its comma
	function automatic logic number_done(input logic [7:0] b);
		logic [63:0] digit;
		digit = {56'd0, b - CH_ZERO};
		number_done = 1'b0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			// a digit that would pass 2^64-1 only marks overflow
			if (acc > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
				acc_overflow = 1'b1;
			else
				acc = acc * 64'd10 + digit;
			acc_has_digit = 1'b1;
		end else if (!acc_has_digit) begin
			err_code = ST_BAD_LEN;
		end else if (acc_overflow) begin
			err_code = ST_INCOMPLETE;
		end else if (b != CH_COMMA) begin
			err_code = ST_BAD_DELIM;
		end else begin
			number_done = 1'b1;
		end
	endfunction

	// expected result for one accepted byte, advancing the model state
	function automatic out_item_t parse_wal_byte(input in_item_t item);
		out_item_t r;
		logic [7:0] b;
		logic [7:0] hdr_want;
		r = '0;
		b = item.data_byte;
		byte_pos = byte_pos + 32'd1;
		hdr_want = (hdr_pos < 3'd4) ? MAGIC_TEXT[8 * (3 - hdr_pos) +: 8] : WAL_VERSION;

		if (err_code != ST_CLEAN) begin
			// sticky error: byte ignored until the verdict
		end else if (hdr_pos < HEADER_LEN) begin
			if (b != hdr_want)
				err_code = ST_BAD_HEADER;
			else
				hdr_pos = hdr_pos + 3'd1;
		end else begin
			case (phase)
				P_BATCH_COUNT: begin
					if (number_done(b)) begin
						records_left = acc;
						clear_number();
						// an empty batch commits on its own comma
						if (records_left == 0) begin
							r.batch_commit = 1'b1;
							commit_pos = byte_pos;
						end else begin
							phase = P_OPCODE;
						end
					end
				end
				P_OPCODE: begin
					// any byte is taken here; a wrong one shows up at the comma
					if (b == CH_PUT) begin
						rec_is_delete = 1'b0;
						phase = P_OPCODE_SEP;
					end else if (b == CH_DEL) begin
						rec_is_delete = 1'b1;
						phase = P_OPCODE_SEP;
					end else begin
						phase = P_OPCODE_SEP_BAD;
					end
				end
				P_OPCODE_SEP: begin
					if (b == CH_COMMA)
						phase = P_SEQUENCE;
					else
						err_code = ST_BAD_DELIM;
				end
				P_OPCODE_SEP_BAD: begin
					err_code = (b == CH_COMMA) ? ST_BAD_OP : ST_BAD_DELIM;
				end
				P_SEQUENCE: begin
					if (number_done(b)) begin
						rec_seq = acc;
						clear_number();
						phase = P_KEY_LEN;
					end
				end
				P_KEY_LEN, P_VALUE_LEN: begin
					if (number_done(b)) begin
						bytes_left = acc;
						clear_number();
						// zero length jumps straight to the terminator
						if (phase == P_KEY_LEN) begin
							if (bytes_left != 0)
								phase = P_KEY_BYTES;
							else
								phase = P_EQUALS;
						end else begin
							if (bytes_left != 0)
								phase = P_VALUE_BYTES;
							else
								phase = P_NEWLINE;
						end
					end
				end
				P_KEY_BYTES, P_VALUE_BYTES: begin
					r.byte_kind = (phase == P_KEY_BYTES) ? KIND_KEY : KIND_VALUE;
					r.payload_byte = b;
					bytes_left = bytes_left - 64'd1;
					if (bytes_left == 0) begin
						if (phase == P_KEY_BYTES)
							phase = P_EQUALS;
						else
							phase = P_NEWLINE;
					end
				end
				P_EQUALS: begin
					if (b == CH_EQUALS)
						phase = P_VALUE_LEN;
					else
						err_code = ST_BAD_DELIM;
				end
				P_NEWLINE: begin
					if (b == CH_NL) begin
						r.byte_kind = KIND_RECORD;
						r.is_tombstone = rec_is_delete;
						r.sequence_number = rec_seq;
						records_left = records_left - 64'd1;
						if (records_left == 0) begin
							r.batch_commit = 1'b1;
							commit_pos = byte_pos;
							phase = P_BATCH_COUNT;
						end else begin
							phase = P_OPCODE;
						end
					end else begin
						err_code = ST_BAD_DELIM;
					end
				end
				default: begin
					phase = P_BATCH_COUNT;
					clear_number();
				end
			endcase
		end

		if (item.last_byte) begin
			r.verdict_valid = 1'b1;
			// clean only on a batch boundary or right after the header
			if (err_code != ST_CLEAN)
				r.parse_status = err_code;
			else if (hdr_pos < HEADER_LEN)
				r.parse_status = ST_BAD_HEADER;
			else if (phase == P_BATCH_COUNT && !acc_has_digit)
				r.parse_status = ST_CLEAN;
			else
				r.parse_status = ST_INCOMPLETE;
			r.good_offset = commit_pos;
			verdict_tally[r.parse_status]++;
			// the next byte opens a new image
			reset_parser_model();
		end

		if (r.byte_kind == KIND_RECORD)
			records_seen++;
		if (r.batch_commit)
			commits_seen++;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// transaction driver and result checker
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		in_item_t item;
		out_item_t predicted;
		item.data_byte = b;
		item.last_byte = is_last;
		// random gap before the byte, on whatever phase the parser is in
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			log_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		log_valid <= 1'b1;
		log_data <= item;
		@(posedge clk);
		while (log_stall)
			@(posedge clk);
		predicted = parse_wal_byte(item);
		expected_results.insert(expected_results.size(), predicted);
		bytes_sent++;
	endtask

	// hold the sender off until every owed result has come back
	task automatic wait_for_results();
		log_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// random receiver back-pressure
	always @(posedge clk)
		res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	function automatic string describe(input out_item_t r);
		return $sformatf("kind %0d byte %02h tomb %0b seq %0d commit %0b verdict %0b status %0d offset %0d",
			r.byte_kind, r.payload_byte, r.is_tombstone, r.sequence_number,
			r.batch_commit, r.verdict_valid, r.parse_status, r.good_offset);
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("cycle %0d: result with nothing expected: %s", cycle_count,
						describe(res_data));
			end else begin
				want = expected_results.pop_front();
				if (res_data.byte_kind !== want.byte_kind ||
						res_data.payload_byte !== want.payload_byte ||
						res_data.is_tombstone !== want.is_tombstone ||
						res_data.sequence_number !== want.sequence_number ||
						res_data.batch_commit !== want.batch_commit ||
						res_data.verdict_valid !== want.verdict_valid ||
						res_data.parse_status !== want.parse_status ||
						res_data.good_offset !== want.good_offset) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("cycle %0d: mismatch", cycle_count);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(res_data));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// image construction
	// ------------------------------------------------------------------------
	// appends one byte to the image under construction
	task automatic add_byte(input logic [7:0] b);
		image_bytes.insert(image_bytes.size(), b);
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			add_byte(s[i]);
	endtask

	task automatic push_number(input logic [63:0] v);
		push_text($sformatf("%0d", v));
	endtask

	task automatic push_header();
		push_text("LWAL");
		add_byte(WAL_VERSION);
	endtask

	// one record with random key and value content
	task automatic push_record(input logic [7:0] op, input logic [63:0] seq_no,
			input int key_len, input int val_len);
		add_byte(op);
		add_byte(CH_COMMA);
		push_number(seq_no);
		add_byte(CH_COMMA);
		push_number(64'(key_len));
		add_byte(CH_COMMA);
		repeat (key_len)
			add_byte(8'($urandom_range(255)));
		add_byte(CH_EQUALS);
		push_number(64'(val_len));
		add_byte(CH_COMMA);
		repeat (val_len)
			add_byte(8'($urandom_range(255)));
		add_byte(CH_NL);
	endtask

	// sends the image built so far, flagging its final byte
	task automatic send_image();
		int n;
		n = image_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(image_bytes[i], i == n - 1);
		image_bytes.delete();
		images_sent++;
	endtask

	task automatic send_after_header(input string body);
		push_header();
		push_text(body);
		send_image();
	endtask

	function automatic logic [63:0] pick_sequence();
		case ($urandom_range(3))
			0: return 64'($urandom_range(999));
			1: return {$urandom, $urandom};
			2: return 64'hFFFF_FFFF_FFFF_FFFF;
			default: return 64'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_opcode();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 8'($urandom_range(255));
		return r[0] ? CH_PUT : CH_DEL;
	endfunction

	function automatic int pick_length();
		return ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
	endfunction

	// random image: mostly well formed, some damaged, cut short or noise
	task automatic build_random_image();
		int shape;
		int count;
		int cut;
		int idx;
		shape = $urandom_range(99);
		if (shape < 85) begin
			if (shape < 2) begin
				push_text("LWAL");
				add_byte(8'($urandom_range(255)));
			end else begin
				push_header();
			end
			repeat ($urandom_range(1, 3)) begin
				count = $urandom_range(0, 3);
				if ($urandom_range(9) == 0)
					add_byte(CH_ZERO);
				push_number(64'(count));
				add_byte(CH_COMMA);
				repeat (count)
					push_record(pick_opcode(), pick_sequence(), pick_length(), pick_length());
			end
			if (shape >= 60 && shape < 72) begin
				// one byte overwritten anywhere
				idx = $urandom_range(image_bytes.size() - 1);
				image_bytes[idx] = 8'($urandom_range(255));
			end else if (shape >= 72) begin
				// image runs out early
				cut = $urandom_range(1, image_bytes.size());
				while (image_bytes.size() > cut)
					image_bytes.delete(image_bytes.size() - 1);
			end
		end else if (shape < 95) begin
			if ($urandom_range(1))
				push_header();
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom_range(255)));
		end else begin
			// a sequence that overflows 64 bits
			push_header();
			push_text("1,P,9");
			repeat (19)
				add_byte(CH_ZERO + 8'($urandom_range(9)));
			push_text(",0,=0,\n");
		end
		send_image();
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_header_checks();
		push_header();
		send_image();
		push_text("LWXL");
		add_byte(WAL_VERSION);
		push_text("0,");
		send_image();
		push_text("LWAL");
		add_byte(8'd2);
		send_image();
		// image ends inside the header
		push_text("LW");
		send_image();
		add_byte(8'hFF);
		send_image();
	endtask

	task automatic test_record_framing();
		// put and delete, largest sequence, zero lengths, empty batch at the end
		send_after_header("2,P,7,3,abc=2,xy\nD,18446744073709551615,0,=0,\n0,");
		// key bytes at both extremes, a newline as value content
		push_header();
		push_text("1,P,0,2,");
		add_byte(8'h00);
		add_byte(8'hFF);
		push_text("=1,\n\n");
		send_image();
		// cut mid-batch after a committed one keeps the earlier boundary
		send_after_header("1,D,3,1,k=1,v\n2,P,4");
		send_after_header("3");
	endtask

	task automatic test_corrupt_fields();
		send_after_header("1,X,1,0,=0,\n");
		send_after_header("1,XY");
		send_after_header("1,P;");
		send_after_header("1,P,,");
		send_after_header(",");
		send_after_header("1,P,5;");
		send_after_header("1,P,5,1,ab");
		send_after_header("1,P,5,0,0");
		send_after_header("1,P,5,0,=0,x");
	endtask

	task automatic test_number_overflow();
		send_after_header("1,P,99999999999999999999,0,=0,\n");
		send_after_header("18446744073709551616,");
		send_after_header("1,P,18446744073709551615,18446744073709551616,");
	endtask

	task automatic test_random_images();
		int phase_idle[4];
		int phase_stall[4];
		int target;
		phase_idle = '{0, 54, 0, 29};
		phase_stall = '{0, 0, 54, 29};
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			target = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < target)
				build_random_image();
			wait_for_results();
		end
	endtask

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("log_record_stream_parser_tb failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		log_valid = 1'b0;
		log_data = '0;
		res_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		fail_count = 0;
		bytes_sent = 0;
		images_sent = 0;
		records_seen = 0;
		commits_seen = 0;
		foreach (verdict_tally[i])
			verdict_tally[i] = 0;
		reset_parser_model();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_header_checks();
		test_record_framing();
		test_corrupt_fields();
		test_number_overflow();
		wait_for_results();
		test_random_images();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d images, %0d bytes: %0d records, %0d batch commits",
			images_sent, bytes_sent, records_seen, commits_seen);
		$display("verdicts clean %0d incomplete %0d header %0d op %0d length %0d delimiter %0d",
			verdict_tally[ST_CLEAN], verdict_tally[ST_INCOMPLETE], verdict_tally[ST_BAD_HEADER],
			verdict_tally[ST_BAD_OP], verdict_tally[ST_BAD_LEN], verdict_tally[ST_BAD_DELIM]);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("log_record_stream_parser_tb passed");
		else
			$display("log_record_stream_parser_tb failed");
		$finish;
	end

endmodule

// ----- log_record_stream_parser.f -----
rtl/lrsp_pkg.sv
rtl/lrsp_core.sv
rtl/log_record_stream_parser.sv
rtl/lrsp_checker.sv
bench/log_record_stream_parser_tb.sv
